// ===== src/bbca_pkg.sv =====
// ----------------------------------------------------------------------------
// bbca_pkg
// Shared types and constants of the blob centroid and aspect unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bbca_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int RATIO_W   = 10;
  localparam int COUNT_W   = 12;
  localparam int TOTAL_W   = 23;
  localparam int SUM_W     = 34;
  localparam int CENT_W    = 11;
  localparam int CLASS_W   = 2;
  localparam int Q_FRAC    = 8;
  localparam int PROD_W    = COUNT_W + RATIO_W;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_RATIO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_RATIO  = 2'd3;

  localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 12'd480;
  localparam logic [RATIO_W-1:0] RST_SMALL_RATIO  = 10'd166;
  localparam logic [RATIO_W-1:0] RST_LARGE_RATIO  = 10'd333;

  localparam logic [CLASS_W-1:0] CLS_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_SMALL = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_LARGE = 2'd2;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_run;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/bbca_ram.sv =====
// ----------------------------------------------------------------------------
// bbca_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbca_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bbca_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbca_ctrl
// Sequencer: pixel read and update, end of frame division, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module bbca_ctrl import bbca_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_ACCEPT = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_LOAD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_ACCEPT: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.frame_end ? S_DIV : S_ACCEPT;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_ACCEPT;
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bbca_dpath.sv =====
// ----------------------------------------------------------------------------
// bbca_dpath
// Config registers, column count memory, frame accumulators, divider and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbca_dpath import bbca_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   pixel_in,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  input  wire logic                   m_tready,
  output logic                        m_tvalid,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int QW  = (XW > YW) ? XW : YW;
  localparam int SW  = (QW > 1) ? $clog2(QW) : 1;
  localparam int DW  = (SUM_W > TOTAL_W + QW) ? SUM_W : TOTAL_W + QW;
  localparam int LXW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int LYW = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [RATIO_W-1:0] small_ratio_q8;
  logic [RATIO_W-1:0] large_ratio_q8;

  logic               pix;
  logic [XW-1:0]      col_pos;
  logic [YW-1:0]      row_pos;
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] max_row;
  logic [COUNT_W-1:0] max_col;
  logic [TOTAL_W-1:0] total;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;

  logic [TOTAL_W-1:0] res_total;
  logic [COUNT_W-1:0] res_max_row;
  logic [COUNT_W-1:0] res_max_col;
  logic [DW-1:0]      rem_x;
  logic [DW-1:0]      rem_y;
  logic [DW-1:0]      dsh;
  logic [QW-1:0]      quo_x;
  logic [QW-1:0]      quo_y;
  logic [SW-1:0]      step;

  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] col_count;
  logic [COUNT_W-1:0] row_count_next;
  logic [COUNT_W-1:0] max_row_next;
  logic [COUNT_W-1:0] max_col_next;
  logic [TOTAL_W-1:0] total_next;
  logic [SUM_W-1:0]   sum_x_next;
  logic [SUM_W-1:0]   sum_y_next;
  logic [XW-1:0]      last_col;
  logic [YW-1:0]      last_row;
  logic [LXW-1:0]     width_ext;
  logic [LYW-1:0]     height_ext;
  logic               row_end;
  logic               frame_end;
  logic               fit_x;
  logic               fit_y;

  logic               has;
  logic [PROD_W-1:0]  r_scaled;
  logic [PROD_W-1:0]  small_prod;
  logic [PROD_W-1:0]  large_prod;
  logic [CLASS_W-1:0] cls;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      small_ratio_q8 <= RST_SMALL_RATIO;
      large_ratio_q8 <= RST_LARGE_RATIO;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width    <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height   <= cfg_wdata;
        REG_SMALL_RATIO:  small_ratio_q8 <= cfg_wdata[RATIO_W-1:0];
        REG_LARGE_RATIO:  large_ratio_q8 <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // last column and row index, zero acts as one, large values saturate
  always_comb begin
    width_ext  = LXW'(frame_width);
    height_ext = LYW'(frame_height);
    if (frame_width == '0) begin
      last_col = '0;
    end else if (width_ext > LXW'(MAX_WIDTH)) begin
      last_col = XW'(MAX_WIDTH - 1);
    end else begin
      last_col = XW'(width_ext - LXW'(1));
    end
    if (frame_height == '0) begin
      last_row = '0;
    end else if (height_ext > LYW'(MAX_HEIGHT)) begin
      last_row = YW'(MAX_HEIGHT - 1);
    end else begin
      last_row = YW'(height_ext - LYW'(1));
    end
  end

  bbca_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_WIDTH)
  ) u_col_ram (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(col_pos),
    .wdata(col_count),
    .raddr(col_pos),
    .rdata(ram_rdata)
  );

  // first row writes the pixel, later rows accumulate
  always_comb begin
    col_count      = (row_pos == '0) ? COUNT_W'(pix) : ram_rdata + COUNT_W'(pix);
    row_count_next = ((col_pos == '0) ? '0 : row_count) + COUNT_W'(pix);
    max_col_next   = (col_count > max_col) ? col_count : max_col;
    max_row_next   = (row_count_next > max_row) ? row_count_next : max_row;
    total_next     = total + TOTAL_W'(pix);
    sum_x_next     = pix ? sum_x + SUM_W'(col_pos) : sum_x;
    sum_y_next     = pix ? sum_y + SUM_W'(row_pos) : sum_y;
    row_end        = (col_pos >= last_col);
    frame_end      = row_end && (row_pos >= last_row);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= pixel_in;
    end
  end

  // frame accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      row_count <= '0;
      max_row   <= '0;
      max_col   <= '0;
      total     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
    end else if (cmd.update) begin
      if (frame_end) begin
        col_pos   <= '0;
        row_pos   <= '0;
        row_count <= '0;
        max_row   <= '0;
        max_col   <= '0;
        total     <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
      end else begin
        row_count <= row_count_next;
        max_row   <= max_row_next;
        max_col   <= max_col_next;
        total     <= total_next;
        sum_x     <= sum_x_next;
        sum_y     <= sum_y_next;
        if (row_end) begin
          col_pos <= '0;
          row_pos <= row_pos + YW'(1);
        end else begin
          col_pos <= col_pos + XW'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle for both coordinates
  always_comb begin
    fit_x = (rem_x >= dsh);
    fit_y = (rem_y >= dsh);
  end

  always_ff @(posedge clk) begin
    if (cmd.update && frame_end) begin
      res_total   <= total_next;
      res_max_row <= max_row_next;
      res_max_col <= max_col_next;
      rem_x       <= DW'(sum_x_next);
      rem_y       <= DW'(sum_y_next);
      dsh         <= DW'(total_next) << (QW - 1);
      quo_x       <= '0;
      quo_y       <= '0;
      step        <= SW'(QW - 1);
    end else if (cmd.div_run) begin
      if (fit_x) begin
        rem_x <= rem_x - dsh;
      end
      if (fit_y) begin
        rem_y <= rem_y - dsh;
      end
      quo_x <= {quo_x[QW-2:0], fit_x};
      quo_y <= {quo_y[QW-2:0], fit_y};
      dsh   <= dsh >> 1;
      step  <= step - SW'(1);
    end
  end

  // side class by cross-multiplication
  always_comb begin
    has        = (res_total != '0);
    r_scaled   = PROD_W'(res_max_row) << Q_FRAC;
    small_prod = PROD_W'(small_ratio_q8) * PROD_W'(res_max_col);
    large_prod = PROD_W'(large_ratio_q8) * PROD_W'(res_max_col);
    if (!has || r_scaled < small_prod) begin
      cls = CLS_NONE;
    end else if (r_scaled < large_prod) begin
      cls = CLS_SMALL;
    end else begin
      cls = CLS_LARGE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_total, res_max_col, res_max_row, cls, has,
                  has ? CENT_W'(quo_y) : CENT_W'(0),
                  has ? CENT_W'(quo_x) : CENT_W'(0)};
    end
  end

  always_comb begin
    status.frame_end = frame_end;
    status.div_done  = (step == '0);
    status.out_busy  = m_tvalid && !m_tready;
  end

endmodule

`default_nettype wire

// ===== src/binary_blob_centroid_and_aspect_unit.sv =====
// ----------------------------------------------------------------------------
// binary_blob_centroid_and_aspect_unit
// Binary mask centroid and row/column projection classifier, one result
// per frame.
// ----------------------------------------------------------------------------
// pixel flow: column count ram read, then update, before the next pixel
// result: the restoring divider makes Q quotient bits after the last pixel
//   beat of a frame, Q = clog2(max(MAX_WIDTH, MAX_HEIGHT)), then the result
//   is registered; one quotient bit per cycle and input waits meanwhile
// reset: config back to defaults, frame accumulators cleared, column ram
//   not cleared (first row of each frame writes it)
// ----------------------------------------------------------------------------
`default_nettype none

module binary_blob_centroid_and_aspect_unit import bbca_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // pixel_set, zero pad
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata    // centroid_x, centroid_y,
                                                 // has_pixels, side_class,
                                                 // max_row_count, max_col_count,
                                                 // set_pixel_total
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bbca_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  bbca_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .pixel_in (s_tdata[0]),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
